// ===== design/ifm_pkg.sv =====
package ifm_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SIDE_REG_W = 13;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COSINE = 8'd3;

  localparam logic [SIDE_REG_W-1:0]    RST_WIDTH  = 13'd512;
  localparam logic [SIDE_REG_W-1:0]    RST_HEIGHT = 13'd512;
  localparam logic signed [COEF_W-1:0] RST_SINE   = 16'sd16384;
  localparam logic signed [COEF_W-1:0] RST_COSINE = 16'sd0;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  typedef struct packed {
    logic [SIDE_REG_W-1:0]    width;
    logic [SIDE_REG_W-1:0]    height;
    logic signed [COEF_W-1:0] sine;
    logic signed [COEF_W-1:0] cosine;
  } ifm_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ifm_qstat_t;

endpackage

// ===== design/image_rotate_forward_map.sv =====
// image rotation by forward mapping about the image center
// input channel: one greyscale pixel per item in raster order on pixel_value_i,
//   handshake src_valid_i / src_stall_o
// output channel: destination column, row and pixel on dest_x_o, dest_y_o,
//   dest_pixel_o, handshake dst_valid_o / dst_stall_i
// a pixel whose rotated position falls outside the image produces no item
// configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 width, 1 height, 2 sine, 3 cosine, 14 fraction bits); others ignored
// throughput: one item per cycle unless dst_stall_i holds the output; a four
//   entry queue sits between the front counters and the back multiply stage
// path: an accepted pixel passes the queue register, the product register
//   and the output register, in that order
// stall: the output register holds while it is valid and dst_stall_i is high;
//   the queue keeps taking pixels until it is full, then src_stall_o rises
// reset: counters go to column 0 row 0, registers to 512, 512, sine 1.0,
//   cosine 0, and queue and pipeline empty
module image_rotate_forward_map #(
  parameter int unsigned MAX_SIDE  = 4096,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ifm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ifm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            src_valid_i,
  output logic                            src_stall_o,
  input  logic [ifm_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                            dst_valid_o,
  input  logic                            dst_stall_i,
  output logic [ifm_pkg::COORD_W-1:0]     dest_x_o,
  output logic [ifm_pkg::COORD_W-1:0]     dest_y_o,
  output logic [ifm_pkg::PIX_W-1:0]       dest_pixel_o
);
  import ifm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned QW = 2 * DW + PIX_W;

  ifm_cfg_t      cfg_q;
  logic [SW-1:0] w_side, h_side;
  logic [CW-1:0] xc, yc;

  ifm_qstat_t    q_stat;
  logic          push, pop;
  logic [DW-1:0] f_dx, f_dy;
  logic [QW-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= RST_WIDTH;
      cfg_q.height <= RST_HEIGHT;
      cfg_q.sine   <= RST_SINE;
      cfg_q.cosine <= RST_COSINE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  cfg_q.width  <= cfg_wdata_i[SIDE_REG_W-1:0];
        REG_HEIGHT: cfg_q.height <= cfg_wdata_i[SIDE_REG_W-1:0];
        REG_SINE:   cfg_q.sine   <= $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COSINE: cfg_q.cosine <= $signed(cfg_wdata_i[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // zero reads as one, large values saturate
  always_comb begin
    if (cfg_q.width == '0) begin
      w_side = SW'(1);
    end else if (32'(cfg_q.width) > MAX_SIDE) begin
      w_side = SW'(MAX_SIDE);
    end else begin
      w_side = SW'(cfg_q.width);
    end
    if (cfg_q.height == '0) begin
      h_side = SW'(1);
    end else if (32'(cfg_q.height) > MAX_SIDE) begin
      h_side = SW'(MAX_SIDE);
    end else begin
      h_side = SW'(cfg_q.height);
    end
  end

  assign xc = w_side[SW-1:1];
  assign yc = h_side[SW-1:1];

  assign src_stall_o = q_stat.full;

  ifm_front #(
    .SW (SW),
    .CW (CW),
    .DW (DW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .w_i         (w_side),
    .h_i         (h_side),
    .xc_i        (xc),
    .yc_i        (yc),
    .src_valid_i (src_valid_i),
    .full_i      (q_stat.full),
    .push_o      (push),
    .dx_o        (f_dx),
    .dy_o        (f_dy)
  );

  assign q_wdata = {f_dx, f_dy, pixel_value_i};

  ifm_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .data_i (q_wdata),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  ifm_back #(
    .SW        (SW),
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW),
    .DW        (DW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dx_i         (q_rdata[QW-1 -: DW]),
    .dy_i         (q_rdata[PIX_W +: DW]),
    .pix_i        (q_rdata[PIX_W-1:0]),
    .empty_i      (q_stat.empty),
    .pop_o        (pop),
    .w_i          (w_side),
    .h_i          (h_side),
    .xc_i         (xc),
    .yc_i         (yc),
    .sine_i       (cfg_q.sine),
    .cosine_i     (cfg_q.cosine),
    .dst_valid_o  (dst_valid_o),
    .dst_stall_i  (dst_stall_i),
    .dest_x_o     (dest_x_o),
    .dest_y_o     (dest_y_o),
    .dest_pixel_o (dest_pixel_o)
  );

`ifndef ASSERT_OFF
  a_push_fills_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_stat.empty) |=> !q_stat.empty)
    else $error("queue empty after push into empty queue");

  a_full_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_stat.empty)
    else $error("queue both full and empty");

  a_pop_needs_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== design/ifm_front.sv =====
module ifm_front #(
  parameter int unsigned SW = 13,
  parameter int unsigned CW = SW - 1,
  parameter int unsigned DW = SW + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [SW-1:0] w_i,
  input  logic [SW-1:0] h_i,
  input  logic [CW-1:0] xc_i,
  input  logic [CW-1:0] yc_i,
  input  logic          src_valid_i,
  input  logic          full_i,
  output logic          push_o,
  output logic [DW-1:0] dx_o,
  output logic [DW-1:0] dy_o
);
  import ifm_pkg::*;

  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic [SW-1:0] col_inc;
  logic [SW-1:0] row_inc;

  assign push_o = src_valid_i && !full_i;

  // offsets from the center, signed
  assign dx_o = {2'b00, col_q} - {2'b00, xc_i};
  assign dy_o = {2'b00, row_q} - {2'b00, yc_i};

  assign col_inc = {1'b0, col_q} + SW'(1);
  assign row_inc = {1'b0, row_q} + SW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (col_inc >= w_i) begin
        col_d = '0;
        if (row_inc >= h_i) begin
          row_d = '0;
        end else begin
          row_d = row_inc[CW-1:0];
        end
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== design/ifm_fifo.sv =====
module ifm_fifo #(
  parameter int unsigned W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                pop_i,
  input  logic [W-1:0]        data_i,
  output logic [W-1:0]        data_o,
  output ifm_pkg::ifm_qstat_t stat_o
);
  import ifm_pkg::*;

  logic [W-1:0]       mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/ifm_back.sv =====
module ifm_back #(
  parameter int unsigned SW        = 13,
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned CW        = SW - 1,
  parameter int unsigned DW        = SW + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [DW-1:0]                       dx_i,
  input  logic [DW-1:0]                       dy_i,
  input  logic [ifm_pkg::PIX_W-1:0]           pix_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  input  logic [SW-1:0]                       w_i,
  input  logic [SW-1:0]                       h_i,
  input  logic [CW-1:0]                       xc_i,
  input  logic [CW-1:0]                       yc_i,
  input  logic signed [ifm_pkg::COEF_W-1:0]   sine_i,
  input  logic signed [ifm_pkg::COEF_W-1:0]   cosine_i,
  output logic                                dst_valid_o,
  input  logic                                dst_stall_i,
  output logic [ifm_pkg::COORD_W-1:0]         dest_x_o,
  output logic [ifm_pkg::COORD_W-1:0]         dest_y_o,
  output logic [ifm_pkg::PIX_W-1:0]           dest_pixel_o
);
  import ifm_pkg::*;

  localparam int unsigned PW  = DW + COEF_W;
  localparam int unsigned AW0 = (PW + 1 > SW + FRAC_BITS) ? PW + 1 : SW + FRAC_BITS;
  localparam int unsigned AW  = AW0 + 1;
  localparam int unsigned FW  = AW - FRAC_BITS;

  logic                 adv;
  logic                 va_q;
  logic signed [PW-1:0] pxc_q, pys_q, pxs_q, pyc_q;
  logic [PIX_W-1:0]     pix_a_q;

  logic [AW-1:0]        acc_x, acc_y;
  logic [FW-1:0]        fl_x, fl_y;
  logic                 ok_x, ok_y;
  logic [COORD_W-1:0]   x_val, y_val;

  logic                 out_v_q;
  logic [COORD_W-1:0]   x_q, y_q;
  logic [PIX_W-1:0]     pix_q;

  assign adv   = !out_v_q || !dst_stall_i;
  assign pop_o = adv && !empty_i;

  // stage a: four products
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pxc_q   <= $signed(dx_i) * cosine_i;
      pys_q   <= $signed(dy_i) * sine_i;
      pxs_q   <= $signed(dx_i) * sine_i;
      pyc_q   <= $signed(dy_i) * cosine_i;
      pix_a_q <= pix_i;
    end
  end

  // stage b: sum, truncate toward zero, range check
  assign acc_x = AW'(pxc_q) - AW'(pys_q) + (AW'(xc_i) << FRAC_BITS);
  assign acc_y = AW'(pxs_q) + AW'(pyc_q) + (AW'(yc_i) << FRAC_BITS);
  assign fl_x  = acc_x[AW-1:FRAC_BITS];
  assign fl_y  = acc_y[AW-1:FRAC_BITS];

  // a negative sum lands inside only when it lies in (-1, 0)
  assign ok_x = acc_x[AW-1] ? ((&fl_x) && (|acc_x[FRAC_BITS-1:0]))
                            : (fl_x < FW'(w_i));
  assign ok_y = acc_y[AW-1] ? ((&fl_y) && (|acc_y[FRAC_BITS-1:0]))
                            : (fl_y < FW'(h_i));
  assign x_val = acc_x[AW-1] ? '0 : COORD_W'(fl_x);
  assign y_val = acc_y[AW-1] ? '0 : COORD_W'(fl_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      va_q    <= !empty_i;
      out_v_q <= va_q && ok_x && ok_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && va_q) begin
      x_q   <= x_val;
      y_q   <= y_val;
      pix_q <= pix_a_q;
    end
  end

  assign dst_valid_o  = out_v_q;
  assign dest_x_o     = x_q;
  assign dest_y_o     = y_q;
  assign dest_pixel_o = pix_q;

endmodule

// ===== bench/image_rotate_forward_map_tb.sv =====
module image_rotate_forward_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifm_pkg::*;

  localparam longint SIDE_MAX = 4096;
  localparam int FRAC = 14;
  localparam longint UNIT = 64'sd1 <<< FRAC;
  localparam int ITEM_GOAL = 1850;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pix;
  } dest_t;

  class rotate_tracker;
    logic [SIDE_REG_W-1:0]    width_q;
    logic [SIDE_REG_W-1:0]    height_q;
    logic signed [COEF_W-1:0] sine_q;
    logic signed [COEF_W-1:0] cosine_q;
    logic [COORD_W-1:0]       col_q;
    logic [COORD_W-1:0]       row_q;
    dest_t                    dest_due[$];
    int                       n_pix;
    int                       n_dest;
    int                       n_bad;

    function new();
      width_q  = RST_WIDTH;
      height_q = RST_HEIGHT;
      sine_q   = RST_SINE;
      cosine_q = RST_COSINE;
      col_q    = '0;
      row_q    = '0;
      n_pix    = 0;
      n_dest   = 0;
      n_bad    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIDTH:  width_q  = data[SIDE_REG_W-1:0];
        REG_HEIGHT: height_q = data[SIDE_REG_W-1:0];
        REG_SINE:   sine_q   = data;
        REG_COSINE: cosine_q = data;
        default: ;
      endcase
    endfunction

    function longint side(logic [SIDE_REG_W-1:0] r);
      if (r == '0) return 1;
      if (longint'(r) > SIDE_MAX) return SIDE_MAX;
      return longint'(r);
    endfunction

    function void take_pixel(logic [PIX_W-1:0] pix);
      longint w, h, xc, yc, dx, dy, ax, ay, xp, yp;
      dest_t d;
      w  = side(width_q);
      h  = side(height_q);
      xc = w / 2;
      yc = h / 2;
      dx = longint'(col_q) - xc;
      dy = longint'(row_q) - yc;
      ax = dx * longint'(cosine_q) - dy * longint'(sine_q) + xc * UNIT;
      ay = dx * longint'(sine_q) + dy * longint'(cosine_q) + yc * UNIT;
      // signed division truncates toward zero
      xp = ax / UNIT;
      yp = ay / UNIT;
      n_pix++;
      if (xp >= 0 && yp >= 0 && xp < w && yp < h) begin
        d.x   = xp[COORD_W-1:0];
        d.y   = yp[COORD_W-1:0];
        d.pix = pix;
        dest_due.push_back(d);
      end
      if (longint'(col_q) + 1 >= w) begin
        col_q = '0;
        if (longint'(row_q) + 1 >= h) begin
          row_q = '0;
        end else begin
          row_q = row_q + 1'b1;
        end
      end else begin
        col_q = col_q + 1'b1;
      end
    endfunction

    function void match_dest(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [PIX_W-1:0] pix);
      dest_t d;
      n_dest++;
      if (dest_due.size() == 0) begin
        n_bad++;
        $display("%0t unexpected item: expected none, got x %0d y %0d pixel %0d",
                 $time, x, y, pix);
        return;
      end
      d = dest_due.pop_front();
      if (x !== d.x) begin
        n_bad++;
        $display("%0t dest_x: expected %0d, got %0d", $time, d.x, x);
      end
      if (y !== d.y) begin
        n_bad++;
        $display("%0t dest_y: expected %0d, got %0d", $time, d.y, y);
      end
      if (pix !== d.pix) begin
        n_bad++;
        $display("%0t dest_pixel: expected %0d, got %0d", $time, d.pix, pix);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  src_valid_i;
  logic                  src_stall_o;
  logic [PIX_W-1:0]      pixel_value_i;
  logic                  dst_valid_o;
  logic                  dst_stall_i;
  logic [COORD_W-1:0]    dest_x_o;
  logic [COORD_W-1:0]    dest_y_o;
  logic [PIX_W-1:0]      dest_pixel_o;

  rotate_tracker tracker = new();
  bit            gaps_on = 1'b1;
  int            n_settings = 0;
  int            n_sent = 0;

  image_rotate_forward_map dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .src_valid_i  (src_valid_i),
    .src_stall_o  (src_stall_o),
    .pixel_value_i(pixel_value_i),
    .dst_valid_o  (dst_valid_o),
    .dst_stall_i  (dst_stall_i),
    .dest_x_o     (dest_x_o),
    .dest_y_o     (dest_y_o),
    .dest_pixel_o (dest_pixel_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src_valid_i && !src_stall_o) tracker.take_pixel(pixel_value_i);
      if (dst_valid_o && !dst_stall_i) tracker.match_dest(dest_x_o, dest_y_o, dest_pixel_o);
    end
  end

  // receiver back-pressure
  initial begin
    dst_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (gaps_on && $urandom_range(0, 6) == 0) begin
        dst_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        dst_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d items still expected", tracker.dest_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      src_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    src_valid_i   <= 1'b1;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (src_stall_o);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    src_valid_i <= 1'b0;
    while (tracker.dest_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] c,
                           input bit stray);
    put_reg(REG_WIDTH, w);
    put_reg(REG_HEIGHT, h);
    put_reg(REG_SINE, s);
    put_reg(REG_COSINE, c);
    if (stray) put_reg(CFG_IDX_W'($urandom_range(REG_COSINE + 1, 255)), CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    n_settings++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    logic [SIDE_REG_W-1:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) v = SIDE_REG_W'($urandom_range(1, 20));
    else if (r == 8) v = SIDE_REG_W'($urandom_range(0, 3));
    else v = SIDE_REG_W'($urandom_range(21, 8191));
    return {3'($urandom), v};
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] s, c;
    real ang;
    int r, len;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    src_valid_i   = 1'b0;
    pixel_value_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting, then shrink the width to the running column
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'h80);
    send_pixel(8'h01);
    drain();
    configure(16'd4, 16'd4, 16'h0000, 16'h4000, 1'b1);
    for (int k = 0; k < 16; k++) send_pixel(k[0] ? 8'hff - 8'(k) : 8'(k * 17));
    drain();
    configure(16'd0, 16'd0, 16'h7fff, 16'h8000, 1'b0);
    send_pixel(8'h55);
    send_pixel(8'haa);
    drain();
    configure(16'hffff, 16'd2, 16'hc000, 16'h4000, 1'b1);
    send_pixel(8'h7f);
    send_pixel(8'hfe);
    send_pixel(8'h3c);
    drain();

    while (n_sent < ITEM_GOAL) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        ang = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
        s = CFG_DATA_W'($rtoi($sin(ang) * 16384.0));
        c = CFG_DATA_W'($rtoi($cos(ang) * 16384.0));
      end else if (r < 17) begin
        s = CFG_DATA_W'($urandom);
        c = CFG_DATA_W'($urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: s = 16'h8000;
          1: s = 16'h7fff;
          2: s = 16'h4000;
          3: s = 16'hc000;
          default: s = 16'h0000;
        endcase
        case ($urandom_range(0, 4))
          0: c = 16'h8000;
          1: c = 16'h7fff;
          2: c = 16'h4000;
          3: c = 16'hc000;
          default: c = 16'h0000;
        endcase
      end
      gaps_on = 1'b0;
      configure(pick_side(), pick_side(), s, c, $urandom_range(0, 2) == 0);
      gaps_on = (n_sent < ITEM_GOAL - 200) && ($urandom_range(0, 3) != 0);
      len = $urandom_range(40, 200);
      for (int k = 0; k < len; k++) send_pixel(PIX_W'($urandom_range(0, 255)));
      drain();
    end

    gaps_on = 1'b0;
    repeat (10) @(posedge clk_i);
    $display("%0d pixels sent over %0d register settings, %0d destination items checked",
             tracker.n_pix, n_settings, tracker.n_dest);
    if (tracker.n_bad == 0 && tracker.dest_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
